// ===== src/ptrgb_pkg.sv =====
// ptrgb_pkg: constants and fixed-point formats for the Planckian temperature to RGB unit.
// Used by planckian_temperature_to_rgb_unit; no dependencies.
package ptrgb_pkg;

    localparam int OUT_FRAC_BITS = 15;
    localparam int IN_W          = 16;
    localparam int LVL_W         = 16;
    localparam int OUT_DATA_W    = 3 * LVL_W;

    localparam logic [IN_W-1:0] KELVIN_MIN = 16'd1000;
    localparam logic [IN_W-1:0] KELVIN_MAX = 16'd40000;

    // polynomial coefficients, units of 1e-16
    localparam logic [63:0] UN0 = 64'd8601177570000000;
    localparam logic [63:0] UN1 = 64'd1541182540000;
    localparam logic [63:0] UN2 = 64'd1286412120;
    localparam logic [63:0] UD0 = 64'd10000000000000000;
    localparam logic [63:0] UD1 = 64'd8424202350000;
    localparam logic [63:0] UD2 = 64'd7081451630;
    localparam logic [63:0] VN0 = 64'd3173987260000000;
    localparam logic [63:0] VN1 = 64'd422806245000;
    localparam logic [63:0] VN2 = 64'd420481691;
    localparam logic [63:0] VD0 = 64'd10000000000000000;
    localparam logic [63:0] VD1 = 64'd289741816000;
    localparam logic [63:0] VD2 = 64'd1614560530;

    localparam int POLY_SH = 4;
    localparam int Q_FRAC  = 32;

    // u, v divider: 60-bit operands, 32 quotient bits
    localparam int UV_W  = 64 - POLY_SH;
    localparam int UV_QW = Q_FRAC;

    // x, z divider: 35-bit dividend, 33-bit divisor, 36 quotient bits
    localparam int XZ_NW = 35;
    localparam int XZ_DW = Q_FRAC + 1;
    localparam int XZ_QW = 36;
    localparam int XZ_SH = XZ_QW - Q_FRAC;
    localparam int ZN_W  = 37;
    localparam int XS_W  = XZ_QW + 1;

    // sRGB matrix, units of 1e-7; Y = 1.0 folded into constants
    localparam int MAT_W = 26;
    localparam logic signed [MAT_W-1:0] MAT_X [3] = '{
        26'sd32404542, -26'sd9692660, 26'sd556434};
    localparam logic signed [MAT_W-1:0] MAT_Z [3] = '{
        -26'sd4985314, 26'sd415560, 26'sd10572252};
    localparam logic signed [63:0] MAT_Y [3] = '{
        -(64'sd15371385 <<< Q_FRAC), (64'sd18760108 <<< Q_FRAC),
        -(64'sd2040259 <<< Q_FRAC)};
    localparam logic signed [63:0] DIV_FLOOR = 64'sd100 <<< Q_FRAC;

    // level divider
    localparam int LV_W  = 63;
    localparam int LV_QW = OUT_FRAC_BITS;
    localparam logic [OUT_FRAC_BITS:0] LVL_ONE = (OUT_FRAC_BITS + 1)'(1) << OUT_FRAC_BITS;

    // pipeline stage positions
    localparam int ST_UV0  = 4;
    localparam int ST_XZP  = ST_UV0 + UV_QW;
    localparam int ST_XZ0  = ST_XZP + 1;
    localparam int ST_SGN  = ST_XZ0 + XZ_QW;
    localparam int ST_MAX2 = ST_SGN + 4;
    localparam int ST_LVP  = ST_MAX2 + 1;
    localparam int ST_OUT  = ST_LVP + 1 + LV_QW;
    localparam int DEPTH   = ST_OUT + 1;

endpackage

// ===== src/planckian_temperature_to_rgb_unit.sv =====
// planckian_temperature_to_rgb_unit: kelvin in, normalized linear sRGB out (Q1.15).
// Depends on ptrgb_pkg.
//
// Accepts one temperature request per clock while the output is not
// stalled and returns one RGB result per request, in order, through the
// ptrgb_pkg::DEPTH pipeline stages. Most of the pipeline is the three chains of
// restoring dividers (u/v, x/z, channel normalize), each retiring one
// quotient bit per pipeline stage. Input is clamped to 1000..40000 K.
// A stall on the output holds the whole pipeline; nothing is dropped.
module planckian_temperature_to_rgb_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ptrgb_pkg::IN_W-1:0]       s_axis_tdata,  // temperature_kelvin
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ptrgb_pkg::OUT_DATA_W-1:0] m_axis_tdata   // red, green, blue level
);
    import ptrgb_pkg::*;

    logic en;
    logic vld_reg [DEPTH];

    assign en            = !vld_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < DEPTH; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // clamp, square, products, polynomials
    logic [IN_W-1:0]   k_reg;
    logic [IN_W-1:0]   k1_reg;
    logic [2*IN_W-1:0] k2_reg;
    logic [63:0]       p_reg [8];
    logic [UV_W-1:0]   uv_n0_reg [2];
    logic [UV_W-1:0]   uv_d0_reg [2];
    logic [63:0]       un_next, ud_next, vn_next, vd_next;

    assign un_next = UN0 + p_reg[0] + p_reg[1];
    assign ud_next = UD0 + p_reg[2] + p_reg[3];
    assign vn_next = VN0 + p_reg[4] + p_reg[5];
    assign vd_next = VD0 + p_reg[7] - p_reg[6];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (s_axis_tdata < KELVIN_MIN)
                k_reg <= KELVIN_MIN;
            else if (s_axis_tdata > KELVIN_MAX)
                k_reg <= KELVIN_MAX;
            else
                k_reg <= s_axis_tdata;
            k1_reg <= k_reg;
            k2_reg <= (2*IN_W)'(k_reg) * (2*IN_W)'(k_reg);
            p_reg[0] <= UN1 * 64'(k1_reg);
            p_reg[1] <= UN2 * 64'(k2_reg);
            p_reg[2] <= UD1 * 64'(k1_reg);
            p_reg[3] <= UD2 * 64'(k2_reg);
            p_reg[4] <= VN1 * 64'(k1_reg);
            p_reg[5] <= VN2 * 64'(k2_reg);
            p_reg[6] <= VD1 * 64'(k1_reg);
            p_reg[7] <= VD2 * 64'(k2_reg);
            uv_n0_reg[0] <= un_next[63:POLY_SH];
            uv_d0_reg[0] <= ud_next[63:POLY_SH];
            uv_n0_reg[1] <= vn_next[63:POLY_SH];
            uv_d0_reg[1] <= vd_next[63:POLY_SH];
        end
    end

    // u, v dividers
    logic [UV_W-1:0]  uv_r_reg [2][UV_QW];
    logic [UV_W-1:0]  uv_d_reg [2][UV_QW];
    logic [UV_QW-1:0] uv_q_reg [2][UV_QW];

    for (genvar l = 0; l < 2; l++)
    begin : g_uv_lane
        for (genvar j = 0; j < UV_QW; j++)
        begin : g_uv_st
            logic [UV_W-1:0]  r_in;
            logic [UV_W-1:0]  d_in;
            logic [UV_QW-1:0] q_in;
            logic [UV_W:0]    t;
            logic             ge;
            if (j == 0)
            begin : g_first
                assign r_in = uv_n0_reg[l];
                assign d_in = uv_d0_reg[l];
                assign q_in = '0;
            end
            else
            begin : g_rest
                assign r_in = uv_r_reg[l][j-1];
                assign d_in = uv_d_reg[l][j-1];
                assign q_in = uv_q_reg[l][j-1];
            end
            assign t  = {r_in, 1'b0};
            assign ge = t >= (UV_W+1)'(d_in);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    uv_r_reg[l][j] <= ge ? UV_W'(t - (UV_W+1)'(d_in)) : UV_W'(t);
                    uv_d_reg[l][j] <= d_in;
                    uv_q_reg[l][j] <= {q_in[UV_QW-2:0], ge};
                end
            end
        end
    end

    // x, z dividend prep
    logic [UV_QW-1:0]       u_q, v_q;
    logic signed [ZN_W-1:0] zn;
    logic [XZ_NW-1:0]       xz_n0_reg [2];
    logic [XZ_DW-1:0]       xz_d0_reg;
    logic                   xz_neg0_reg;

    assign u_q = uv_q_reg[0][UV_QW-1];
    assign v_q = uv_q_reg[1][UV_QW-1];
    assign zn  = (ZN_W'(64'sd4) <<< Q_FRAC) - $signed(ZN_W'(u_q))
               - $signed(ZN_W'(v_q)) * ZN_W'(64'sd10);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xz_n0_reg[0] <= XZ_NW'(u_q) * XZ_NW'(3);
            xz_n0_reg[1] <= zn[ZN_W-1] ? XZ_NW'(-zn) : XZ_NW'(zn);
            xz_d0_reg    <= {v_q, 1'b0};
            xz_neg0_reg  <= zn[ZN_W-1];
        end
    end

    // x, z dividers
    logic [XZ_DW-1:0] xz_r_reg [2][XZ_QW];
    logic [XZ_QW-1:0] xz_t_reg [2][XZ_QW];
    logic [XZ_QW-1:0] xz_q_reg [2][XZ_QW];
    logic [XZ_DW-1:0] xz_d_reg [XZ_QW];
    logic             xz_neg_reg [XZ_QW];

    for (genvar j = 0; j < XZ_QW; j++)
    begin : g_xz_ctl
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                xz_d_reg[j]   <= (j == 0) ? xz_d0_reg : xz_d_reg[(j == 0) ? 0 : j-1];
                xz_neg_reg[j] <= (j == 0) ? xz_neg0_reg : xz_neg_reg[(j == 0) ? 0 : j-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_xz_lane
        for (genvar j = 0; j < XZ_QW; j++)
        begin : g_xz_st
            logic [XZ_DW-1:0] r_in;
            logic [XZ_DW-1:0] d_in;
            logic [XZ_QW-1:0] tl_in;
            logic [XZ_QW-1:0] q_in;
            logic [XZ_DW:0]   t;
            logic             ge;
            if (j == 0)
            begin : g_first
                assign r_in  = XZ_DW'(xz_n0_reg[l] >> XZ_SH);
                assign d_in  = xz_d0_reg;
                assign tl_in = {xz_n0_reg[l][XZ_SH-1:0], {Q_FRAC{1'b0}}};
                assign q_in  = '0;
            end
            else
            begin : g_rest
                assign r_in  = xz_r_reg[l][j-1];
                assign d_in  = xz_d_reg[j-1];
                assign tl_in = xz_t_reg[l][j-1];
                assign q_in  = xz_q_reg[l][j-1];
            end
            assign t  = {r_in, tl_in[XZ_QW-1]};
            assign ge = t >= (XZ_DW+1)'(d_in);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    xz_r_reg[l][j] <= ge ? XZ_DW'(t - (XZ_DW+1)'(d_in)) : XZ_DW'(t);
                    xz_t_reg[l][j] <= {tl_in[XZ_QW-2:0], 1'b0};
                    xz_q_reg[l][j] <= {q_in[XZ_QW-2:0], ge};
                end
            end
        end
    end

    // sign, matrix, max
    logic signed [XS_W-1:0] xs_reg, zs_reg;
    logic signed [63:0]     mp_reg [3][2];
    logic signed [63:0]     ch_reg [3];
    logic signed [63:0]     ch1_reg [3];
    logic signed [63:0]     ch2_reg [3];
    logic signed [63:0]     mx1_reg, mx2_reg, mm_reg;
    logic signed [XS_W-1:0] zq;

    assign zq = $signed({1'b0, xz_q_reg[1][XZ_QW-1]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xs_reg <= $signed({1'b0, xz_q_reg[0][XZ_QW-1]});
            zs_reg <= xz_neg_reg[XZ_QW-1] ? -zq : zq;
            for (int c = 0; c < 3; c++)
            begin
                mp_reg[c][0] <= 64'(MAT_X[c]) * 64'(xs_reg);
                mp_reg[c][1] <= 64'(MAT_Z[c]) * 64'(zs_reg);
                ch_reg[c]    <= mp_reg[c][0] + MAT_Y[c] + mp_reg[c][1];
                ch1_reg[c]   <= ch_reg[c];
                ch2_reg[c]   <= ch1_reg[c];
            end
            mx1_reg <= (ch_reg[0] > DIV_FLOOR) ? ch_reg[0] : DIV_FLOOR;
            mx2_reg <= (ch_reg[1] > ch_reg[2]) ? ch_reg[1] : ch_reg[2];
            mm_reg  <= (mx1_reg > mx2_reg) ? mx1_reg : mx2_reg;
        end
    end

    // level prep and dividers
    logic [LV_W-1:0]  lv_n0_reg [3];
    logic [LV_W-1:0]  lv_d0_reg;
    logic             lv_z0_reg [3];
    logic             lv_f0_reg [3];
    logic [LV_W-1:0]  lv_r_reg [3][LV_QW];
    logic [LV_QW-1:0] lv_q_reg [3][LV_QW];
    logic             lv_z_reg [3][LV_QW];
    logic             lv_f_reg [3][LV_QW];
    logic [LV_W-1:0]  lv_d_reg [LV_QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lv_d0_reg <= LV_W'(mm_reg);
            for (int c = 0; c < 3; c++)
            begin
                lv_n0_reg[c] <= LV_W'(ch2_reg[c]);
                lv_z0_reg[c] <= ch2_reg[c] <= 64'sd0;
                lv_f0_reg[c] <= ch2_reg[c] >= mm_reg;
            end
        end
    end

    for (genvar j = 0; j < LV_QW; j++)
    begin : g_lv_ctl
        always_ff @(posedge clk)
        begin
            if (en)
                lv_d_reg[j] <= (j == 0) ? lv_d0_reg : lv_d_reg[(j == 0) ? 0 : j-1];
        end
    end

    for (genvar l = 0; l < 3; l++)
    begin : g_lv_lane
        for (genvar j = 0; j < LV_QW; j++)
        begin : g_lv_st
            logic [LV_W-1:0]  r_in;
            logic [LV_W-1:0]  d_in;
            logic [LV_QW-1:0] q_in;
            logic             z_in, f_in;
            logic [LV_W:0]    t;
            logic             ge;
            if (j == 0)
            begin : g_first
                assign r_in = lv_n0_reg[l];
                assign d_in = lv_d0_reg;
                assign q_in = '0;
                assign z_in = lv_z0_reg[l];
                assign f_in = lv_f0_reg[l];
            end
            else
            begin : g_rest
                assign r_in = lv_r_reg[l][j-1];
                assign d_in = lv_d_reg[j-1];
                assign q_in = lv_q_reg[l][j-1];
                assign z_in = lv_z_reg[l][j-1];
                assign f_in = lv_f_reg[l][j-1];
            end
            assign t  = {r_in, 1'b0};
            assign ge = t >= (LV_W+1)'(d_in);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    lv_r_reg[l][j] <= ge ? LV_W'(t - (LV_W+1)'(d_in)) : LV_W'(t);
                    lv_q_reg[l][j] <= (LV_QW > 1) ? LV_QW'({q_in, ge}) : LV_QW'(ge);
                    lv_z_reg[l][j] <= z_in;
                    lv_f_reg[l][j] <= f_in;
                end
            end
        end
    end

    // output register
    logic [OUT_FRAC_BITS:0] out_lvl_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (lv_f_reg[c][LV_QW-1])
                    out_lvl_reg[c] <= LVL_ONE;
                else if (lv_z_reg[c][LV_QW-1])
                    out_lvl_reg[c] <= '0;
                else
                    out_lvl_reg[c] <= (OUT_FRAC_BITS+1)'(lv_q_reg[c][LV_QW-1]);
            end
        end
    end

    assign m_axis_tdata = {LVL_W'(out_lvl_reg[2]), LVL_W'(out_lvl_reg[1]),
                           LVL_W'(out_lvl_reg[0])};

    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_OUT] |-> (out_lvl_reg[0] <= LVL_ONE) && (out_lvl_reg[1] <= LVL_ONE)
                            && (out_lvl_reg[2] <= LVL_ONE))
        else $error("level above full scale");

    a_max_floor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_MAX2] |-> (mm_reg >= DIV_FLOOR))
        else $error("normalize divisor below floor");

    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_LVP] |-> !(lv_z0_reg[0] && lv_f0_reg[0]) && !(lv_z0_reg[1] && lv_f0_reg[1])
                            && !(lv_z0_reg[2] && lv_f0_reg[2]))
        else $error("channel both zero and full");

    a_xz_div: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_XZP] |-> (xz_d0_reg != '0))
        else $error("zero divisor for x and z");

endmodule
